// File: design/rsch_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsch_pkg
// Shared types and constants for the ray / sphere closest-hit block.
// ----------------------------------------------------------------------------
package rsch_pkg;

  // sphere table word: {radius, cz, cy, cx}
  localparam int ENTRY_W = 127;

  // accumulator of the shared multiply-add unit
  localparam int ACC_W = 106;

  localparam logic [17:0] ONE_Q16   = 18'd65536;
  localparam logic [30:0] DIST_SAT  = 31'h7fff_ffff;

  // sequencer step bounds
  localparam logic [5:0] CALC_LAST = 6'd11;
  localparam logic [5:0] SQ_LAST   = 6'd50;
  localparam logic [5:0] FIN_LAST  = 6'd21;
  localparam logic [5:0] DV_FIRST  = 6'd4;
  localparam logic [5:0] DV_LAST   = 6'd20;
  localparam logic [1:0] AXIS_LAST = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_LD,
    ST_CALC,
    ST_CHK,
    ST_SQ,
    ST_PICK,
    ST_END,
    ST_FIN,
    ST_OUT
  } state_t;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_CAST,
    OP_LOAD,
    OP_H0,
    OP_H1,
    OP_H2,
    OP_OC0,
    OP_OC1,
    OP_OC2,
    OP_R2,
    OP_A0,
    OP_A1,
    OP_A2,
    OP_A3,
    OP_A4,
    OP_SQ,
    OP_PICK,
    OP_P0,
    OP_P1,
    OP_HIT,
    OP_DV0,
    OP_DV,
    OP_NRM,
    OP_OUT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [1:0] axis;
  } ctrl_t;

  typedef struct packed {
    logic rad_zero;
    logic delta_neg;
    logic best_valid;
  } status_t;

endpackage

// File: design/rsch_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsch_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module rsch_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/rsch_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsch_dp
// Datapath: one shared multiply-add unit and one shared compare-subtract
// unit, stepped by the sequencer for the sphere tests and the hit output.
// ----------------------------------------------------------------------------
module rsch_dp import rsch_pkg::*; #(
  parameter int AW = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  ctrl_t               ctrl,
  input  logic [AW-1:0]       idx,
  input  logic signed [31:0]  in_point_x,
  input  logic signed [31:0]  in_point_y,
  input  logic signed [31:0]  in_point_z,
  input  logic signed [17:0]  in_dir_x,
  input  logic signed [17:0]  in_dir_y,
  input  logic signed [17:0]  in_dir_z,
  input  logic [ENTRY_W-1:0]  rdata,
  output status_t             status,
  output logic                out_strobe,
  output logic                out_hit_found,
  output logic [30:0]         out_hit_distance,
  output logic signed [31:0]  out_hit_x,
  output logic signed [31:0]  out_hit_y,
  output logic signed [31:0]  out_hit_z,
  output logic signed [17:0]  out_normal_x,
  output logic signed [17:0]  out_normal_y,
  output logic signed [17:0]  out_normal_z,
  output logic [3:0]          out_hit_slot
);

  logic signed [31:0] px_r, py_r, pz_r;
  logic signed [17:0] dx_r, dy_r, dz_r;
  logic signed [31:0] cx_r, cy_r, cz_r;
  logic [30:0]        rad_r;
  logic signed [32:0] ox_r, oy_r, oz_r;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic signed [52:0] h_r;
  logic [65:0]        oc2_r;
  logic [61:0]        r2_r;
  logic [51:0]        rem_r;
  logic [50:0]        root_r;
  logic [46:0]        ds_r;
  logic [52:0]        best_t_r;
  logic [AW-1:0]      best_idx_r;
  logic signed [31:0] bcx_r, bcy_r, bcz_r;
  logic [30:0]        brad_r;
  logic               best_valid_r;
  logic signed [31:0] hit_r [3];
  logic signed [17:0] norm_r [3];
  logic               neg_r, sat_r;

  // operand selection
  logic signed [31:0] sel_p, sel_bc;
  logic signed [17:0] sel_d;
  logic [32:0]        absx, absy, absz;
  logic [51:0]        hmag;
  logic [36:0]        t16;

  always_comb begin
    case (ctrl.axis)
      2'd1: begin
        sel_p = py_r; sel_bc = bcy_r; sel_d = dy_r;
      end
      2'd2: begin
        sel_p = pz_r; sel_bc = bcz_r; sel_d = dz_r;
      end
      default: begin
        sel_p = px_r; sel_bc = bcx_r; sel_d = dx_r;
      end
    endcase
  end

  assign absx = ox_r[32] ? 33'(-ox_r) : 33'(ox_r);
  assign absy = oy_r[32] ? 33'(-oy_r) : 33'(oy_r);
  assign absz = oz_r[32] ? 33'(-oz_r) : 33'(oz_r);
  assign hmag = h_r[52] ? 52'(-h_r) : 52'(h_r);
  assign t16  = best_t_r[52:16];

  // shared multiply-add unit
  logic signed [33:0]      ma, mb;
  logic signed [67:0]      prod;
  logic signed [ACC_W-1:0] prodx;

  always_comb begin
    ma = '0;
    mb = '0;
    case (ctrl.op)
      OP_H0:  begin ma = {ox_r[32], ox_r}; mb = {{16{dx_r[17]}}, dx_r}; end
      OP_H1:  begin ma = {oy_r[32], oy_r}; mb = {{16{dy_r[17]}}, dy_r}; end
      OP_H2:  begin ma = {oz_r[32], oz_r}; mb = {{16{dz_r[17]}}, dz_r}; end
      OP_OC0: begin ma = {1'b0, absx}; mb = {1'b0, absx}; end
      OP_OC1: begin ma = {1'b0, absy}; mb = {1'b0, absy}; end
      OP_OC2: begin ma = {1'b0, absz}; mb = {1'b0, absz}; end
      OP_R2:  begin ma = {3'b0, rad_r}; mb = {3'b0, rad_r}; end
      OP_A0:  begin ma = {9'b0, hmag[24:0]}; mb = {9'b0, hmag[24:0]}; end
      OP_A1:  begin ma = {7'b0, hmag[51:25]}; mb = {9'b0, hmag[24:0]}; end
      OP_A2:  begin ma = {7'b0, hmag[51:25]}; mb = {7'b0, hmag[51:25]}; end
      OP_P0:  begin ma = {{16{sel_d[17]}}, sel_d}; mb = {14'b0, t16[19:0]}; end
      OP_P1:  begin ma = {{16{sel_d[17]}}, sel_d}; mb = {17'b0, t16[36:20]}; end
      default: begin ma = '0; mb = '0; end
    endcase
  end

  assign prod  = ma * mb;
  assign prodx = {{(ACC_W-68){prod[67]}}, prod};

  always_comb begin
    case (ctrl.op)
      OP_H0, OP_OC0, OP_R2, OP_A0, OP_P0: acc_nxt = prodx;
      OP_H1, OP_H2, OP_OC1, OP_OC2:       acc_nxt = acc_r + prodx;
      // cross term 2*hh*hl at weight 2^25
      OP_A1:  acc_nxt = acc_r + (prodx <<< 26);
      OP_A2:  acc_nxt = acc_r + (prodx <<< 50);
      OP_A3:  acc_nxt = acc_r + $signed({12'b0, r2_r, 32'b0});
      OP_A4:  acc_nxt = acc_r - $signed({8'b0, oc2_r, 32'b0});
      OP_P1:  acc_nxt = acc_r + (prodx <<< 20);
      OP_SQ:  acc_nxt = acc_r <<< 2;
      default: acc_nxt = acc_r;
    endcase
  end

  // shared compare-subtract unit (square root and division steps)
  logic [53:0] csa, csb, csd;
  logic        ge;

  always_comb begin
    if (ctrl.op == OP_SQ) begin
      csa = {rem_r, acc_r[101:100]};
      csb = {1'b0, root_r, 2'b01};
    end else begin
      csa = {2'b0, rem_r};
      csb = {7'b0, ds_r};
    end
  end

  assign ge  = csa >= csb;
  assign csd = csa - csb;

  // root selection and best-hit compare
  logic        origin_in;
  logic signed [53:0] t_s, rootx, hx;
  logic        better;

  assign origin_in = oc2_r < {4'b0, r2_r};
  assign rootx  = $signed({3'b0, root_r});
  assign hx     = {h_r[52], h_r};
  assign t_s    = origin_in ? (rootx - hx) : (-hx - rootx);
  assign better = !t_s[53] && (!best_valid_r || (t_s[52:0] < best_t_r));

  // hit point coordinate
  logic signed [40:0] hsum;
  logic signed [31:0] hclamp;

  assign hsum = $signed({{9{sel_p[31]}}, sel_p}) + $signed(acc_r[56:16]);

  always_comb begin
    if (hsum > 41'sd2147483647) begin
      hclamp = 32'sh7fff_ffff;
    end else if (hsum < -41'sd2147483648) begin
      hclamp = 32'sh8000_0000;
    end else begin
      hclamp = hsum[31:0];
    end
  end

  // normal setup and final clamp
  logic signed [32:0] ndiff;
  logic [32:0]        nabs;
  logic [17:0]        qv;

  assign ndiff = {hit_r[ctrl.axis][31], hit_r[ctrl.axis]} - {sel_bc[31], sel_bc};
  assign nabs  = ndiff[32] ? 33'(-ndiff) : 33'(ndiff);
  assign qv    = (sat_r || (root_r[16:0] > ONE_Q16[16:0] && root_r[16])) ? ONE_Q16
               : {1'b0, root_r[16:0]};

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    unique case (ctrl.op)
      OP_CAST: begin
        px_r <= in_point_x; py_r <= in_point_y; pz_r <= in_point_z;
        dx_r <= in_dir_x;   dy_r <= in_dir_y;   dz_r <= in_dir_z;
      end
      OP_LOAD: begin
        cx_r  <= rdata[31:0];
        cy_r  <= rdata[63:32];
        cz_r  <= rdata[95:64];
        rad_r <= rdata[126:96];
        ox_r  <= {px_r[31], px_r} - {rdata[31], rdata[31:0]};
        oy_r  <= {py_r[31], py_r} - {rdata[63], rdata[63:32]};
        oz_r  <= {pz_r[31], pz_r} - {rdata[95], rdata[95:64]};
      end
      OP_OC0: h_r   <= acc_r[52:0];
      OP_R2:  oc2_r <= acc_r[65:0];
      OP_A0:  r2_r  <= acc_r[61:0];
      OP_A4: begin
        rem_r  <= '0;
        root_r <= '0;
      end
      OP_SQ, OP_DV: begin
        rem_r  <= ge ? csd[51:0] : csa[51:0];
        root_r <= {root_r[49:0], ge};
        ds_r   <= ds_r >> 1;
      end
      OP_PICK: begin
        if (better) begin
          best_t_r   <= t_s[52:0];
          best_idx_r <= idx;
          bcx_r      <= cx_r;
          bcy_r      <= cy_r;
          bcz_r      <= cz_r;
          brad_r     <= rad_r;
        end
      end
      OP_HIT: hit_r[ctrl.axis] <= hclamp;
      OP_DV0: begin
        neg_r  <= ndiff[32];
        sat_r  <= nabs >= {1'b0, brad_r, 1'b0};
        rem_r  <= {3'b0, nabs, 16'b0};
        ds_r   <= {brad_r, 16'b0};
        root_r <= '0;
      end
      OP_NRM: norm_r[ctrl.axis] <= neg_r ? -$signed(qv) : $signed(qv);
      OP_OUT: begin
        out_hit_found    <= best_valid_r;
        out_hit_distance <= !best_valid_r ? '0
                          : (t16 > {6'b0, DIST_SAT}) ? DIST_SAT : t16[30:0];
        out_hit_x        <= best_valid_r ? hit_r[0] : '0;
        out_hit_y        <= best_valid_r ? hit_r[1] : '0;
        out_hit_z        <= best_valid_r ? hit_r[2] : '0;
        out_normal_x     <= best_valid_r ? norm_r[0] : '0;
        out_normal_y     <= best_valid_r ? norm_r[1] : '0;
        out_normal_z     <= best_valid_r ? norm_r[2] : '0;
        out_hit_slot     <= best_valid_r ? 4'({{(9 - AW){1'b0}}, best_idx_r}) : '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_valid_r <= 1'b0;
      out_strobe   <= 1'b0;
    end else begin
      out_strobe <= (ctrl.op == OP_OUT);
      if (ctrl.op == OP_CAST) begin
        best_valid_r <= 1'b0;
      end else if (ctrl.op == OP_PICK && better) begin
        best_valid_r <= 1'b1;
      end
    end
  end

  assign status.rad_zero   = (rad_r == '0);
  assign status.delta_neg  = acc_r[ACC_W-1];
  assign status.best_valid = best_valid_r;

endmodule

// File: design/rsch_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsch_seq
// Sequencer: walks the tested slots, steps the shared units and finishes
// with the hit point and normal, one axis at a time.
// ----------------------------------------------------------------------------
module rsch_seq import rsch_pkg::*; #(
  parameter int MAX_SPHERES = 16,
  parameter int AW = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          in_mode,
  input  logic [4:0]    count,
  input  status_t       status,
  output ctrl_t         ctrl,
  output logic [AW-1:0] idx,
  output logic          busy
);

  localparam logic [8:0] MAX9 = 9'(MAX_SPHERES);

  state_t        state_r, state_nxt;
  logic [5:0]    step_r, step_nxt;
  logic [1:0]    axis_r, axis_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [AW-1:0] last_r, last_nxt;
  logic [8:0]    n9;
  logic          adv;

  always_comb begin
    n9 = (count == 5'd0) ? 9'd1 : {4'b0, count};
    if (n9 > MAX9) begin
      n9 = MAX9;
    end
  end

  function automatic op_t calc_op(input logic [5:0] s);
    op_t o;
    unique case (s)
      6'd0:    o = OP_H0;
      6'd1:    o = OP_H1;
      6'd2:    o = OP_H2;
      6'd3:    o = OP_OC0;
      6'd4:    o = OP_OC1;
      6'd5:    o = OP_OC2;
      6'd6:    o = OP_R2;
      6'd7:    o = OP_A0;
      6'd8:    o = OP_A1;
      6'd9:    o = OP_A2;
      6'd10:   o = OP_A3;
      6'd11:   o = OP_A4;
      default: o = OP_NOP;
    endcase
    return o;
  endfunction

  function automatic op_t fin_op(input logic [5:0] s);
    op_t o;
    if (s == 6'd0) begin
      o = OP_P0;
    end else if (s == 6'd1) begin
      o = OP_P1;
    end else if (s == 6'd2) begin
      o = OP_HIT;
    end else if (s == 6'd3) begin
      o = OP_DV0;
    end else if (s >= DV_FIRST && s <= DV_LAST) begin
      o = OP_DV;
    end else begin
      o = OP_NRM;
    end
    return o;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
      axis_r  <= '0;
      idx_r   <= '0;
      last_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      axis_r  <= axis_nxt;
      idx_r   <= idx_nxt;
      last_r  <= last_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    axis_nxt  = axis_r;
    idx_nxt   = idx_r;
    last_nxt  = last_r;
    ctrl.op   = OP_NOP;
    ctrl.axis = axis_r;
    adv       = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start && in_mode) begin
          ctrl.op   = OP_CAST;
          idx_nxt   = '0;
          last_nxt  = AW'(n9 - 9'd1);
          state_nxt = ST_RD;
        end
      end
      ST_RD: state_nxt = ST_LD;
      ST_LD: begin
        ctrl.op   = OP_LOAD;
        step_nxt  = '0;
        state_nxt = ST_CALC;
      end
      ST_CALC: begin
        if (step_r == 6'd0 && status.rad_zero) begin
          adv = 1'b1;
        end else begin
          ctrl.op = calc_op(step_r);
          if (step_r == CALC_LAST) begin
            state_nxt = ST_CHK;
          end else begin
            step_nxt = step_r + 6'd1;
          end
        end
      end
      ST_CHK: begin
        if (status.delta_neg) begin
          adv = 1'b1;
        end else begin
          step_nxt  = '0;
          state_nxt = ST_SQ;
        end
      end
      ST_SQ: begin
        ctrl.op = OP_SQ;
        if (step_r == SQ_LAST) begin
          state_nxt = ST_PICK;
        end else begin
          step_nxt = step_r + 6'd1;
        end
      end
      ST_PICK: begin
        ctrl.op = OP_PICK;
        adv     = 1'b1;
      end
      ST_END: begin
        step_nxt  = '0;
        axis_nxt  = '0;
        state_nxt = status.best_valid ? ST_FIN : ST_OUT;
      end
      ST_FIN: begin
        ctrl.op = fin_op(step_r);
        if (step_r == FIN_LAST) begin
          step_nxt = '0;
          if (axis_r == AXIS_LAST) begin
            state_nxt = ST_OUT;
          end else begin
            axis_nxt = axis_r + 2'd1;
          end
        end else begin
          step_nxt = step_r + 6'd1;
        end
      end
      ST_OUT: begin
        ctrl.op   = OP_OUT;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
    if (adv) begin
      if (idx_r == last_r) begin
        state_nxt = ST_END;
      end else begin
        idx_nxt   = idx_r + AW'(1);
        state_nxt = ST_RD;
      end
    end
  end

  assign idx  = idx_r;
  assign busy = (state_r != ST_IDLE);

endmodule

// File: design/ray_sphere_closest_hit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_sphere_closest_hit
// Sphere table with closest-hit ray cast in signed Q16.16 fixed point.
// ----------------------------------------------------------------------------
//  channel   ports                          handshake
//  -------   -----------------------------  --------------------------------
//  input     in_* (mode, slot, point, ...)  start & !busy
//  result    out_* (hit, distance, ...)     out_strobe, one cycle, no stall
//  config    cfg_wdata (sphere_count)       cfg_we
//
//  a write word never raises busy; a cast holds busy while it walks the
//  tested slots: a zero-radius slot is skipped, a slot with no real root
//  stops at the discriminant check, else the 51-step square root runs on
//  the shared compare-subtract unit; a hit adds hit point and normals (three
//  17-step divisions); the result word shows at the edge at which busy drops
//  no clearing pass: unwritten table slots read as undefined
//  the receiver cannot stall; each result is shown for one cycle
// ----------------------------------------------------------------------------
module ray_sphere_closest_hit import rsch_pkg::*; #(
  parameter int MAX_SPHERES = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_mode,
  input  logic [3:0]         in_sphere_slot,
  input  logic signed [31:0] in_point_x,
  input  logic signed [31:0] in_point_y,
  input  logic signed [31:0] in_point_z,
  input  logic signed [17:0] in_dir_x,
  input  logic signed [17:0] in_dir_y,
  input  logic signed [17:0] in_dir_z,
  input  logic [30:0]        in_radius,
  output logic               out_strobe,
  output logic               out_hit_found,
  output logic [30:0]        out_hit_distance,
  output logic signed [31:0] out_hit_x,
  output logic signed [31:0] out_hit_y,
  output logic signed [31:0] out_hit_z,
  output logic signed [17:0] out_normal_x,
  output logic signed [17:0] out_normal_y,
  output logic signed [17:0] out_normal_z,
  output logic [3:0]         out_hit_slot,
  input  logic               cfg_we,
  input  logic [4:0]         cfg_wdata
);

  localparam int AW = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;

  logic [4:0]         count_r;
  logic               tbl_we;
  logic [AW-1:0]      idx;
  logic [ENTRY_W-1:0] rdata;
  ctrl_t              ctrl;
  status_t            status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 5'd1;
    end else if (cfg_we) begin
      count_r <= cfg_wdata;
    end
  end

  // slots past the table are dropped
  assign tbl_we = start && !busy && !in_mode
               && ({5'b0, in_sphere_slot} < 9'(MAX_SPHERES));

  rsch_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_SPHERES)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (AW'(in_sphere_slot)),
    .wdata ({in_radius, in_point_z, in_point_y, in_point_x}),
    .raddr (idx),
    .rdata (rdata)
  );

  rsch_seq #(
    .MAX_SPHERES (MAX_SPHERES),
    .AW          (AW)
  ) u_seq (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_mode (in_mode),
    .count   (count_r),
    .status  (status),
    .ctrl    (ctrl),
    .idx     (idx),
    .busy    (busy)
  );

  rsch_dp #(
    .AW (AW)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctrl             (ctrl),
    .idx              (idx),
    .in_point_x       (in_point_x),
    .in_point_y       (in_point_y),
    .in_point_z       (in_point_z),
    .in_dir_x         (in_dir_x),
    .in_dir_y         (in_dir_y),
    .in_dir_z         (in_dir_z),
    .rdata            (rdata),
    .status           (status),
    .out_strobe       (out_strobe),
    .out_hit_found    (out_hit_found),
    .out_hit_distance (out_hit_distance),
    .out_hit_x        (out_hit_x),
    .out_hit_y        (out_hit_y),
    .out_hit_z        (out_hit_z),
    .out_normal_x     (out_normal_x),
    .out_normal_y     (out_normal_y),
    .out_normal_z     (out_normal_z),
    .out_hit_slot     (out_hit_slot)
  );

  // a result word only closes a cast
  a_out_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(busy))
    else $error("result word without a cast in flight");

  a_cast_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_mode) |=> busy)
    else $error("cast word did not start the sequencer");

  a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_mode) |=> !busy)
    else $error("table write word raised busy");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_hit_found) |-> (out_hit_distance == '0 && out_hit_slot == '0))
    else $error("miss word carries nonzero fields");

endmodule

// File: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Closest-hit sphere table test: loads spheres, casts rays and checks every
// result word against an exact fixed-point prediction of the nearest hit.
// ----------------------------------------------------------------------------
module tb import rsch_pkg::*; ();

  localparam int SLOTS    = 16;
  localparam int WD_LIMIT = 40000;
  localparam bit MODE_WRITE = 1'b0;
  localparam bit MODE_CAST  = 1'b1;
  localparam longint Q1 = 65536;

  typedef struct {
    bit                mode;
    bit [3:0]          slot;
    bit signed [31:0]  px, py, pz;
    bit signed [17:0]  dx, dy, dz;
    bit [30:0]         radius;
  } word_t;

  typedef struct {
    bit                found;
    bit [30:0]         distance;
    bit signed [31:0]  hx, hy, hz;
    bit signed [17:0]  nx, ny, nz;
    bit [3:0]          slot;
  } hit_t;

  class hit_scoreboard;
    longint cen_x[SLOTS], cen_y[SLOTS], cen_z[SLOTS], rad[SLOTS];
    bit [4:0] count;
    hit_t pending[$];
    int errors;

    function new();
      count = 1;
      errors = 0;
      for (int i = 0; i < SLOTS; i++) begin
        cen_x[i] = 0; cen_y[i] = 0; cen_z[i] = 0; rad[i] = 0;
      end
    endfunction

    function void report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endfunction

    function void set_count(bit [4:0] v);
      count = v;
    endfunction

    static function longint root_floor(bit [127:0] n);
      longint res;
      bit [127:0] cand;
      res = 0;
      for (int k = 52; k >= 0; k--) begin
        cand = res | (longint'(1) << k);
        if (n >= cand * cand) res = cand;
      end
      return res;
    endfunction

    static function longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function void note(word_t w);
      longint ox, oy, oz, h, t, best_t, t16, hx, hy, hz, dx, dy, dz;
      bit [127:0] mx, my, mz, mh, oc2, r2, a, bb;
      int best, n;
      hit_t r;
      if (w.mode == MODE_WRITE) begin
        cen_x[w.slot] = w.px; cen_y[w.slot] = w.py; cen_z[w.slot] = w.pz;
        rad[w.slot] = w.radius;
        return;
      end
      dx = w.dx; dy = w.dy; dz = w.dz;
      n = (count == 0) ? 1 : (count > SLOTS ? SLOTS : count);
      best = -1;
      best_t = 0;
      for (int i = 0; i < n; i++) begin
        if (rad[i] == 0) continue;
        ox = longint'(w.px) - cen_x[i];
        oy = longint'(w.py) - cen_y[i];
        oz = longint'(w.pz) - cen_z[i];
        h = ox * dx + oy * dy + oz * dz;
        mx = ox < 0 ? -ox : ox;
        my = oy < 0 ? -oy : oy;
        mz = oz < 0 ? -oz : oz;
        mh = h < 0 ? -h : h;
        oc2 = mx * mx + my * my + mz * mz;
        r2 = 128'(rad[i]) * 128'(rad[i]);
        a = mh * mh + (r2 << 32);
        bb = oc2 << 32;
        if (a < bb) continue;
        // inside the sphere the far root is the exit point
        if (oc2 < r2) t = -h + root_floor(a - bb);
        else t = -h - root_floor(a - bb);
        if (t < 0) continue;
        if (best < 0 || t < best_t) begin
          best = i;
          best_t = t;
        end
      end
      r = '{default: 0};
      if (best >= 0) begin
        t16 = best_t >>> 16;
        hx = clamp(longint'(w.px) + ((dx * t16) >>> 16), -(longint'(1) << 31),
                   (longint'(1) << 31) - 1);
        hy = clamp(longint'(w.py) + ((dy * t16) >>> 16), -(longint'(1) << 31),
                   (longint'(1) << 31) - 1);
        hz = clamp(longint'(w.pz) + ((dz * t16) >>> 16), -(longint'(1) << 31),
                   (longint'(1) << 31) - 1);
        r.found = 1;
        r.distance = t16 > 64'h7fff_ffff ? DIST_SAT : 31'(t16);
        r.hx = 32'(hx); r.hy = 32'(hy); r.hz = 32'(hz);
        r.nx = 18'(clamp((hx - cen_x[best]) * Q1 / rad[best], -Q1, Q1));
        r.ny = 18'(clamp((hy - cen_y[best]) * Q1 / rad[best], -Q1, Q1));
        r.nz = 18'(clamp((hz - cen_z[best]) * Q1 / rad[best], -Q1, Q1));
        r.slot = 4'(best);
      end
      pending.push_back(r);
    endfunction

    function void field(string name, longint got, longint want);
      if (got != want) report($sformatf("%s got %0d expected %0d", name, got, want));
    endfunction

    function void check(hit_t g);
      hit_t e;
      if (pending.size() == 0) begin
        report("result word with nothing expected");
        return;
      end
      e = pending.pop_front();
      field("hit_found", g.found, e.found);
      field("hit_distance", g.distance, e.distance);
      field("hit_x", g.hx, e.hx);
      field("hit_y", g.hy, e.hy);
      field("hit_z", g.hz, e.hz);
      field("normal_x", g.nx, e.nx);
      field("normal_y", g.ny, e.ny);
      field("normal_z", g.nz, e.nz);
      field("hit_slot", g.slot, e.slot);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_mode = 1'b0;
  logic [3:0] in_sphere_slot = '0;
  logic signed [31:0] in_point_x = '0, in_point_y = '0, in_point_z = '0;
  logic signed [17:0] in_dir_x = '0, in_dir_y = '0, in_dir_z = '0;
  logic [30:0] in_radius = '0;
  logic out_strobe, out_hit_found;
  logic [30:0] out_hit_distance;
  logic signed [31:0] out_hit_x, out_hit_y, out_hit_z;
  logic signed [17:0] out_normal_x, out_normal_y, out_normal_z;
  logic [3:0] out_hit_slot;
  logic cfg_we = 1'b0;
  logic [4:0] cfg_wdata = '0;

  hit_scoreboard sb = new();
  bit calm = 0;
  int idle_cycles = 0;

  always #4 clk = ~clk;

  ray_sphere_closest_hit dut (
    .clk, .rst_n, .start, .busy,
    .in_mode, .in_sphere_slot, .in_point_x, .in_point_y, .in_point_z,
    .in_dir_x, .in_dir_y, .in_dir_z, .in_radius,
    .out_strobe, .out_hit_found, .out_hit_distance,
    .out_hit_x, .out_hit_y, .out_hit_z,
    .out_normal_x, .out_normal_y, .out_normal_z, .out_hit_slot,
    .cfg_we, .cfg_wdata
  );

  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      hit_t g;
      g.found = out_hit_found; g.distance = out_hit_distance;
      g.hx = out_hit_x; g.hy = out_hit_y; g.hz = out_hit_z;
      g.nx = out_normal_x; g.ny = out_normal_y; g.nz = out_normal_z;
      g.slot = out_hit_slot;
      sb.check(g);
    end
    if ((start && !busy) || out_strobe) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WD_LIMIT) begin
      $display("watchdog expired");
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // start stays high after acceptance so back-to-back words need one assignment
  task automatic send(word_t w);
    if (!calm && $urandom_range(99) < 15) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1'b1;
    in_mode <= w.mode; in_sphere_slot <= w.slot;
    in_point_x <= w.px; in_point_y <= w.py; in_point_z <= w.pz;
    in_dir_x <= w.dx; in_dir_y <= w.dy; in_dir_z <= w.dz;
    in_radius <= w.radius;
    do @(posedge clk); while (busy);
    sb.note(w);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_count(bit [4:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_count(v);
  endtask

  function automatic word_t sphere(int slot, longint x, longint y, longint z, longint r);
    word_t w;
    w = '{default: 0};
    w.mode = MODE_WRITE; w.slot = 4'(slot);
    w.px = 32'(x); w.py = 32'(y); w.pz = 32'(z); w.radius = 31'(r);
    w.dx = 18'($urandom); w.dy = 18'($urandom); w.dz = 18'($urandom);
    return w;
  endfunction

  function automatic word_t ray(longint x, longint y, longint z,
                                longint dx, longint dy, longint dz);
    word_t w;
    w.mode = MODE_CAST; w.slot = 4'($urandom);
    w.px = 32'(x); w.py = 32'(y); w.pz = 32'(z);
    w.dx = 18'(dx); w.dy = 18'(dy); w.dz = 18'(dz);
    w.radius = 31'($urandom);
    return w;
  endfunction

  function automatic longint rnd_q(int span);
    return longint'($urandom_range(2 * span * 65536)) - longint'(span) * Q1;
  endfunction

  function automatic longint rnd_dir();
    return longint'($urandom_range(131072)) - Q1;
  endfunction

  // ray from a random origin pointed at one stored center
  function automatic word_t aimed_ray(int n);
    longint ox, oy, oz;
    real vx, vy, vz, len;
    int s;
    s = $urandom_range(n - 1);
    ox = rnd_q(40); oy = rnd_q(40); oz = rnd_q(40);
    vx = real'(sb.cen_x[s] - ox) + real'(rnd_q(1));
    vy = real'(sb.cen_y[s] - oy) + real'(rnd_q(1));
    vz = real'(sb.cen_z[s] - oz) + real'(rnd_q(1));
    len = $sqrt(vx * vx + vy * vy + vz * vz);
    if (len < 1.0) return ray(ox, oy, oz, Q1, 0, 0);
    return ray(ox, oy, oz, hit_scoreboard::clamp(longint'($rtoi(vx / len * 65536.0)), -Q1, Q1),
               hit_scoreboard::clamp(longint'($rtoi(vy / len * 65536.0)), -Q1, Q1),
               hit_scoreboard::clamp(longint'($rtoi(vz / len * 65536.0)), -Q1, Q1));
  endfunction

  initial begin
    bit [4:0] counts[6] = '{5'd16, 5'd0, 5'd31, 5'd7, 5'd3, 5'd1};
    longint maxp, minp;
    int n, pick;
    maxp = 64'h7fff_ffff;
    minp = -(longint'(1) << 31);
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // fill the whole table first: slots 0 and 1 coincide for the tie case
    send(sphere(0, -30 * Q1, 0, 10 * Q1, Q1));
    send(sphere(1, -30 * Q1, 0, 10 * Q1, Q1));
    for (int i = 2; i < 14; i++) send(sphere(i, (i * 4 - 30) * Q1, 0, 10 * Q1, 2 * Q1));
    send(sphere(14, maxp, 0, 0, Q1));
    send(sphere(15, 0, -1000 * Q1, 0, 0));
    write_count(5'd16);

    send(ray(0, 100 * Q1, 0, 0, Q1, 0));                        // miss
    send(ray(-30 * Q1, 0, 0, 0, 0, Q1));                        // tie, lower slot wins
    send(ray(-22 * Q1, 0, 10 * Q1, Q1, 0, 0));                  // origin inside
    send(ray(minp, 0, 0, Q1, 0, 0));                            // saturated distance
    send(ray(-30 * Q1, 0, 20 * Q1, 0, 0, -Q1));
    send(ray(-30 * Q1, 0, 0, 0, 0, Q1 / 2));                    // non-unit direction
    send(ray(-18 * Q1, 0, 10 * Q1, 0, 0, 0));                   // zero direction
    send(ray(0, -1005 * Q1, 0, 0, Q1, 0));                      // zero radius only
    send(ray(maxp, maxp, maxp, -Q1, -Q1, -Q1));
    send(ray(minp, minp, minp, Q1, Q1, Q1));
    send(ray(maxp - 5 * Q1, 0, 0, Q1, 0, 0));                   // walks into far slot

    for (int k = 0; k < 1800; k++) begin
      if (k % 300 == 0) write_count(counts[k / 300]);
      calm = (k >= 600 && k < 900);
      n = (sb.count == 0) ? 1 : (sb.count > SLOTS ? SLOTS : sb.count);
      pick = $urandom_range(99);
      if (pick < 20)
        send(sphere($urandom_range(SLOTS - 1), rnd_q(32), rnd_q(32), rnd_q(32),
                    longint'($urandom_range(8 * 65536, 32768))));
      else if (pick < 23)
        send(sphere($urandom_range(SLOTS - 1), longint'(32'($urandom)) - 0,
                    longint'(32'($urandom)), longint'(32'($urandom)),
                    longint'($urandom_range(32'h7fff_ffff, 1))));
      else if (pick < 78)
        send(aimed_ray(n));
      else if (pick < 90)
        send(ray(rnd_q(60), rnd_q(60), rnd_q(60), rnd_dir(), rnd_dir(), rnd_dir()));
      else
        send(ray(longint'(signed'(32'($urandom))), longint'(signed'(32'($urandom))),
                 longint'(signed'(32'($urandom))), rnd_dir(), rnd_dir(), rnd_dir()));
    end

    start <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
